// ===== rtl/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// shared types and constants of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
package plti_pkg;

  // fixed width of the energy and value fields on the ports
  localparam int FIELD_W = 32;
  // widest internal energy or value word
  localparam int MAX_W   = 48;

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } plti_mode_t;

  typedef enum logic [0:0] {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } plti_status_t;

  // control part of the query token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    logic below;
  } plti_tok_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } plti_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } plti_md_state_t;

endpackage

// ===== rtl/plti_if.sv =====
// ----------------------------------------------------------------------------
// plti_if
// valid/ready channels of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
interface plti_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  point_index;
  logic [31:0] point_energy;
  logic [31:0] point_value;
  logic [31:0] query_energy;

  modport source (output valid, mode, point_index, point_energy, point_value,
                  query_energy, input ready);
  modport sink   (input valid, mode, point_index, point_energy, point_value,
                  query_energy, output ready);
endinterface

interface plti_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== rtl/plti_cell.sv =====
// ----------------------------------------------------------------------------
// plti_cell
// one breakpoint of the table and one step of the segment search
// ----------------------------------------------------------------------------
module plti_cell #(
  parameter int CELL_IDX = 0,
  parameter int EW       = 32,
  parameter int VW       = 32,
  parameter int CW       = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [7:0]              wr_idx,
  input  logic [EW-1:0]           wr_e,
  input  logic [VW-1:0]           wr_v,
  input  logic [CW-1:0]           n,
  input  plti_pkg::plti_tok_ctl_t ctl_in,
  input  logic [EW-1:0]           q_in,
  input  logic [EW-1:0]           e0_in,
  input  logic [VW-1:0]           v0_in,
  input  logic [EW-1:0]           e1_in,
  input  logic [VW-1:0]           v1_in,
  input  logic [VW-1:0]           fb_in,
  input  logic [EW-1:0]           pe_in,
  input  logic [VW-1:0]           pv_in,
  output plti_pkg::plti_tok_ctl_t ctl_out,
  output logic [EW-1:0]           q_out,
  output logic [EW-1:0]           e0_out,
  output logic [VW-1:0]           v0_out,
  output logic [EW-1:0]           e1_out,
  output logic [VW-1:0]           v1_out,
  output logic [VW-1:0]           fb_out,
  output logic [EW-1:0]           pe_out,
  output logic [VW-1:0]           pv_out
);
  import plti_pkg::*;

  logic [EW-1:0] e_r;
  logic [VW-1:0] v_r;

  plti_tok_ctl_t ctl_r, ctl_nxt;
  logic [EW-1:0] q_r, e0_r, e0_nxt, e1_r, e1_nxt;
  logic [VW-1:0] v0_r, v0_nxt, v1_r, v1_nxt, fb_r, fb_nxt;

  logic in_range;
  logic is_last;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) == 32'(CELL_IDX))) begin
      e_r <= wr_e;
      v_r <= wr_v;
    end
  end

  assign in_range = (CELL_IDX != 0) && (CW'(CELL_IDX) < n);
  assign is_last  = (CW'(CELL_IDX) == n - CW'(1));

  always_comb begin
    ctl_nxt = ctl_in;
    e0_nxt  = e0_in;
    v0_nxt  = v0_in;
    e1_nxt  = e1_in;
    v1_nxt  = v1_in;
    fb_nxt  = fb_in;
    if (CELL_IDX == 0) begin
      ctl_nxt.below = (q_in < e_r);
      if (q_in < e_r) begin
        fb_nxt = v_r;
      end
    end
    if (is_last && !ctl_nxt.below) begin
      fb_nxt = v_r;
    end
    // first segment that holds the query wins
    if (in_range && !ctl_in.found && (q_in >= pe_in) && (q_in <= e_r)) begin
      ctl_nxt.found = 1'b1;
      e0_nxt = pe_in;
      v0_nxt = pv_in;
      e1_nxt = e_r;
      v1_nxt = v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_in;
    e0_r <= e0_nxt;
    v0_r <= v0_nxt;
    e1_r <= e1_nxt;
    v1_r <= v1_nxt;
    fb_r <= fb_nxt;
  end

  assign ctl_out = ctl_r;
  assign q_out   = q_r;
  assign e0_out  = e0_r;
  assign v0_out  = v0_r;
  assign e1_out  = e1_r;
  assign v1_out  = v1_r;
  assign fb_out  = fb_r;
  assign pe_out  = e_r;
  assign pv_out  = v_r;

endmodule

// ===== rtl/plti_muldiv.sv =====
// ----------------------------------------------------------------------------
// plti_muldiv
// exact (a * b) / d by shift-add multiply and restoring divide
// ----------------------------------------------------------------------------
module plti_muldiv #(
  parameter int EW = 32,
  parameter int VW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VW-1:0]      a,
  input  logic [EW-1:0]      b,
  input  logic [EW-1:0]      d,
  output logic               done,
  output logic [VW+EW-1:0]   quo
);
  import plti_pkg::*;

  localparam int P    = VW + EW;
  localparam int CNTW = $clog2(P);

  plti_md_state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic [P-1:0]    mcand_r, mcand_nxt, acc_r, acc_nxt, quo_r, quo_nxt;
  logic [EW-1:0]   mplier_r, mplier_nxt, d_r, d_nxt, rem_r, rem_nxt;
  logic [EW:0]     rem_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    mplier_r <= mplier_nxt;
    d_r      <= d_nxt;
    rem_r    <= rem_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    quo_nxt    = quo_r;
    mplier_nxt = mplier_r;
    d_nxt      = d_r;
    rem_nxt    = rem_r;
    rem_w      = {rem_r, acc_r[P-1]};
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          mcand_nxt  = P'(a);
          mplier_nxt = b;
          d_nxt      = d;
          acc_nxt    = '0;
          rem_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = MD_MUL;
        end
      end
      MD_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(EW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        acc_nxt = acc_r << 1;
        if (rem_w >= {1'b0, d_r}) begin
          rem_nxt = EW'(rem_w - {1'b0, d_r});
          quo_nxt = {quo_r[P-2:0], 1'b1};
        end else begin
          rem_nxt = rem_w[EW-1:0];
          quo_nxt = {quo_r[P-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(P - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/piecewise_linear_table_interp.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// breakpoint table with linear interpolation between neighboring points
// ----------------------------------------------------------------------------
// Write items (mode 0) store one breakpoint in its slot, and the block stays
// ready for the next item. Query items (mode 1) walk a row of TABLE_DEPTH
// cells, one cell per cycle, to find the first segment holding the energy,
// then run a shift-add multiply and a restoring divide. A query that needs
// no divide skips both, and an empty table answers without a scan. One item
// is in work at a time; a finished result sits in the output register while
// the next item is taken. The user must write point_count only while idle;
// the block itself does not enforce it.
module piecewise_linear_table_interp #(
  parameter int TABLE_DEPTH  = 256,
  parameter int ENERGY_WIDTH = 32,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  plti_in_if.sink     in_ch,
  plti_out_if.source  out_ch
);
  import plti_pkg::*;

  localparam int EW = ENERGY_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int P  = EW + VW;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (NW > 9) ? NW : 9;

  // ---- configuration: point count, clamped to the depth
  logic [8:0]    point_count_r;
  logic [CW-1:0] pc_ext, n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_we) begin
      point_count_r <= cfg_wdata;
    end
  end

  assign pc_ext = CW'(point_count_r);
  assign n = (pc_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : pc_ext;

  // ---- input fields masked to the internal widths
  logic [MAX_W-1:0] pe_wide, pv_wide, qe_wide;
  logic [EW-1:0]    wr_e, in_q;
  logic [VW-1:0]    wr_v;
  logic             in_acc, wr_en;

  assign pe_wide = MAX_W'(in_ch.point_energy);
  assign pv_wide = MAX_W'(in_ch.point_value);
  assign qe_wide = MAX_W'(in_ch.query_energy);
  assign wr_e    = pe_wide[EW-1:0];
  assign wr_v    = pv_wide[VW-1:0];
  assign in_q    = qe_wide[EW-1:0];

  plti_state_t state_r, state_nxt;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_en       = in_acc && (in_ch.mode == MODE_WRITE);

  // ---- row of cells
  plti_tok_ctl_t ctl [TABLE_DEPTH+1];
  logic [EW-1:0] q_c  [TABLE_DEPTH+1];
  logic [EW-1:0] e0_c [TABLE_DEPTH+1];
  logic [VW-1:0] v0_c [TABLE_DEPTH+1];
  logic [EW-1:0] e1_c [TABLE_DEPTH+1];
  logic [VW-1:0] v1_c [TABLE_DEPTH+1];
  logic [VW-1:0] fb_c [TABLE_DEPTH+1];
  logic [EW-1:0] pe_c [TABLE_DEPTH+1];
  logic [VW-1:0] pv_c [TABLE_DEPTH+1];

  logic          launch;
  plti_tok_ctl_t ctl_launch;

  // token enters cell 0 when a query starts the scan
  always_comb begin
    ctl_launch       = '0;
    ctl_launch.valid = launch;
  end
  assign ctl[0]  = ctl_launch;
  assign q_c[0]  = in_q;
  assign e0_c[0] = '0;
  assign v0_c[0] = '0;
  assign e1_c[0] = '0;
  assign v1_c[0] = '0;
  assign fb_c[0] = '0;
  assign pe_c[0] = '0;
  assign pv_c[0] = '0;

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    plti_cell #(
      .CELL_IDX (gi),
      .EW       (EW),
      .VW       (VW),
      .CW       (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_idx  (in_ch.point_index),
      .wr_e    (wr_e),
      .wr_v    (wr_v),
      .n       (n),
      .ctl_in  (ctl[gi]),
      .q_in    (q_c[gi]),
      .e0_in   (e0_c[gi]),
      .v0_in   (v0_c[gi]),
      .e1_in   (e1_c[gi]),
      .v1_in   (v1_c[gi]),
      .fb_in   (fb_c[gi]),
      .pe_in   (pe_c[gi]),
      .pv_in   (pv_c[gi]),
      .ctl_out (ctl[gi+1]),
      .q_out   (q_c[gi+1]),
      .e0_out  (e0_c[gi+1]),
      .v0_out  (v0_c[gi+1]),
      .e1_out  (e1_c[gi+1]),
      .v1_out  (v1_c[gi+1]),
      .fb_out  (fb_c[gi+1]),
      .pe_out  (pe_c[gi+1]),
      .pv_out  (pv_c[gi+1])
    );
  end

  // ---- captured segment at the end of the row
  logic          found_r, found_nxt;
  logic [EW-1:0] q_r, q_nxt, e0_r, e0_nxt, e1_r, e1_nxt;
  logic [VW-1:0] v0_r, v0_nxt, v1_r, v1_nxt, fb_r, fb_nxt;

  // ---- multiply-divide unit
  logic          md_start, md_done;
  logic [P-1:0]  md_quo;
  logic [VW-1:0] md_a;
  logic [EW-1:0] md_b, md_d;
  logic          rising;

  assign rising = (v1_r >= v0_r);
  assign md_a   = rising ? (v1_r - v0_r) : (v0_r - v1_r);
  assign md_b   = q_r - e0_r;
  assign md_d   = e1_r - e0_r;

  plti_muldiv #(
    .EW (EW),
    .VW (VW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .quo   (md_quo)
  );

  // saturate the interpolated value to the value range
  logic [P:0]    sum_w;
  logic [VW-1:0] interp_v;

  always_comb begin
    sum_w = (P+1)'(v0_r) + (P+1)'(md_quo);
    if (rising) begin
      interp_v = (sum_w > (P+1)'({VW{1'b1}})) ? {VW{1'b1}} : sum_w[VW-1:0];
    end else begin
      interp_v = (md_quo > P'(v0_r)) ? '0 : (v0_r - md_quo[VW-1:0]);
    end
  end

  // ---- pending result and output register
  logic [VW-1:0] res_r, res_nxt;
  logic          stat_r, stat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_val_r, out_val_nxt;
  logic          out_stat_r, out_stat_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    q_r        <= q_nxt;
    e0_r       <= e0_nxt;
    e1_r       <= e1_nxt;
    v0_r       <= v0_nxt;
    v1_r       <= v1_nxt;
    fb_r       <= fb_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    launch        = 1'b0;
    md_start      = 1'b0;
    found_nxt     = found_r;
    q_nxt         = q_r;
    e0_nxt        = e0_r;
    e1_nxt        = e1_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    fb_nxt        = fb_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.mode == MODE_QUERY)) begin
          if (n == '0) begin
            // empty table answers at once
            res_nxt   = '0;
            stat_nxt  = STATUS_EMPTY;
            state_nxt = ST_EMIT;
          end else begin
            launch    = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ctl[TABLE_DEPTH].valid) begin
          found_nxt = ctl[TABLE_DEPTH].found;
          q_nxt     = q_c[TABLE_DEPTH];
          e0_nxt    = e0_c[TABLE_DEPTH];
          e1_nxt    = e1_c[TABLE_DEPTH];
          v0_nxt    = v0_c[TABLE_DEPTH];
          v1_nxt    = v1_c[TABLE_DEPTH];
          fb_nxt    = fb_c[TABLE_DEPTH];
          stat_nxt  = STATUS_OK;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (!found_r) begin
          // clamped or single point
          res_nxt   = fb_r;
          state_nxt = ST_EMIT;
        end else if (e1_r == e0_r) begin
          // zero-width segment keeps its first value
          res_nxt   = v0_r;
          state_nxt = ST_EMIT;
        end else begin
          md_start  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          res_nxt   = interp_v;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [MAX_W-1:0] out_wide;

  assign out_wide            = MAX_W'(out_val_r);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_wide[FIELD_W-1:0];
  assign out_ch.status       = out_stat_r;

endmodule

// ===== test/piecewise_linear_table_interp_tb.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_tb
// self-checking bench: loads breakpoint tables, queries energies and compares
// every interpolated result with a bench-side model of the table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import plti_pkg::*;

typedef struct packed {
  logic [31:0]  value;
  plti_status_t status;
} interp_result_t;

// table model plus the queue of interpolated results still owed by the block
class interp_board;
  logic [31:0]    energy_tbl [256];
  logic [31:0]    value_tbl  [256];
  logic [8:0]     point_count;
  interp_result_t owed [$];
  int             mismatches;

  function new();
    point_count = 0;
    mismatches  = 0;
  endfunction

  function logic [31:0] segment_value(logic [31:0] e0, logic [31:0] v0,
                                      logic [31:0] e1, logic [31:0] v1,
                                      logic [31:0] q);
    logic [63:0] span, off, prod, m, r;
    if (e1 == e0) return v0;
    span = 64'(e1 - e0);
    off  = 64'(q - e0);
    if (v1 >= v0) begin
      prod = 64'(v1 - v0) * off;
      m = prod / span;
      r = 64'(v0) + m;
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    end
    prod = 64'(v0 - v1) * off;
    m = prod / span;
    return (m > 64'(v0)) ? 32'd0 : 32'(64'(v0) - m);
  endfunction

  function interp_result_t interpolate(logic [31:0] q);
    interp_result_t res;
    int n;
    n = (point_count > 256) ? 256 : point_count;
    res.status = STATUS_OK;
    if (n == 0) begin
      res.value  = 0;
      res.status = STATUS_EMPTY;
      return res;
    end
    if (n == 1) begin
      res.value = value_tbl[0];
      return res;
    end
    // unsorted tables with no hit fall back to the last value
    res.value = value_tbl[n-1];
    if (q < energy_tbl[0]) res.value = value_tbl[0];
    for (int i = 0; i + 1 < n; i++) begin
      if (q >= energy_tbl[i] && q <= energy_tbl[i+1]) begin
        res.value = segment_value(energy_tbl[i], value_tbl[i], energy_tbl[i+1],
                                  value_tbl[i+1], q);
        break;
      end
    end
    return res;
  endfunction

  function void note_item(plti_mode_t mode, logic [7:0] idx, logic [31:0] e,
                          logic [31:0] v, logic [31:0] q);
    if (mode == MODE_WRITE) begin
      energy_tbl[idx] = e;
      value_tbl[idx]  = v;
    end else begin
      owed = {owed, interpolate(q)};
    end
  endfunction

  function void check_result(logic [31:0] value, logic status);
    interp_result_t exp_res;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("error: result %h status %0d with nothing owed", value, status);
      return;
    end
    exp_res = owed.pop_front();
    if (value !== exp_res.value || status !== exp_res.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("error: value exp %h got %h, status exp %0d got %0d",
                 exp_res.value, value, exp_res.status, status);
    end
  endfunction
endclass

module piecewise_linear_table_interp_tb;
  localparam int IDLE_LIMIT  = 4000;  // cycles with no accepted item
  localparam int SETTLE_WAIT = 400;   // settle time at the end of a drain

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;

  plti_in_if  in_ch ();
  plti_out_if out_ch ();

  interp_board board;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;
  int items_sent;

  // most recent sorted table, used to aim queries at segments
  int tbl_n;

  piecewise_linear_table_interp dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #4 clk = ~clk;

  // known values on every input from time zero
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_WRITE;
    in_ch.point_index  = '0;
    in_ch.point_energy = '0;
    in_ch.point_value  = '0;
    in_ch.query_energy = '0;
    out_ch.ready       = 1'b0;
    board              = new();
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
  end

  // receiver stalls, accept monitors and watchdog, all on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (in_ch.valid && in_ch.ready)
        board.note_item(plti_mode_t'(in_ch.mode), in_ch.point_index,
                        in_ch.point_energy, in_ch.point_value, in_ch.query_energy);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.result_value, out_ch.status);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("piecewise_linear_table_interp_tb failed");
        $finish;
      end
    end
  end

  // present one item, with random sender gaps, and hold it until accepted
  task automatic send_item(plti_mode_t mode, logic [7:0] idx, logic [31:0] e,
                           logic [31:0] v, logic [31:0] q);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.point_index  <= idx;
    in_ch.point_energy <= e;
    in_ch.point_value  <= v;
    in_ch.query_energy <= q;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_point(int idx, logic [31:0] e, logic [31:0] v);
    send_item(MODE_WRITE, 8'(idx), e, v, $urandom);
  endtask

  task automatic query(logic [31:0] q);
    send_item(MODE_QUERY, 8'($urandom), $urandom, $urandom, q);
  endtask

  // wait for every owed result, then for a write still in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_point_count(logic [8:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.point_count = n;
  endtask

  // ascending table in slots 0..n-1, with zero-width steps now and then
  task automatic load_sorted(int n);
    logic [63:0] e;
    logic [31:0] v;
    e = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(100000));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0:       v = 32'd0;
        1:       v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      if (i == n - 1 && $urandom_range(2) == 0) e = 64'hFFFF_FFFF;
      write_point(i, e[31:0], v);
      case ($urandom_range(7))
        0:       e = e;                                  // zero-width segment
        1:       e = e + 64'($urandom);                  // wide segment
        default: e = e + 64'($urandom_range(1, 50000));
      endcase
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    end
    tbl_n = n;
  endtask

  // queries aimed at segments, breakpoints, ends and anywhere
  task automatic aimed_query();
    int i;
    logic [31:0] lo, hi;
    i = $urandom_range(tbl_n - 1);
    lo = board.energy_tbl[i];
    hi = (i + 1 < tbl_n) ? board.energy_tbl[i+1] : lo;
    case ($urandom_range(5))
      0:       query(lo);
      1:       query((lo < 32'hFFFF_FFFF) ? lo + 1 : lo);
      2:       query(lo + 32'((64'($urandom) * 64'(hi - lo)) >> 32));
      3:       query($urandom_range(board.energy_tbl[0]));
      4:       query(32'hFFFF_FFFF - $urandom_range(3));
      default: query($urandom);
    endcase
  endtask

  initial begin
    logic [8:0] n;
    int sent_base;
    items_sent = 0;
    tbl_n = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table at both energy extremes
    query(32'd0);
    query(32'hFFFF_FFFF);

    // one point: the energy does not matter
    write_point(0, 32'd500, 32'h0001_0000);
    set_point_count(9'd1);
    query(32'd0);
    query(32'hFFFF_FFFF);

    // four points: zero-width first segment, rising, then falling to zero
    write_point(0, 32'd10, 32'h0001_0000);
    write_point(1, 32'd10, 32'd5);
    write_point(2, 32'd1000, 32'hFFFF_FFFF);
    write_point(3, 32'hFFFF_FFFF, 32'd0);
    set_point_count(9'd4);
    query(32'd0);            // below the first point
    query(32'd10);           // zero-width segment
    query(32'd500);
    query(32'd1000);
    query(32'h8000_0000);    // falling segment
    query(32'hFFFF_FFFF);

    // unsorted: a query beyond every segment
    write_point(3, 32'd20, 32'h1234_5678);
    query(32'd5000);

    // every slot written once, so any count reads defined entries
    src_idle_pct = 0; sink_stall_pct = 0;
    set_point_count(9'd0);
    load_sorted(256);
    set_point_count(9'd256);
    query($urandom);
    query(32'hFFFF_FFFF);
    set_point_count(9'h1FF);   // above the depth, clamps to full table
    query($urandom);

    // random phases share what is left of the item budget
    sent_base = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      while (items_sent < sent_base + 105 * (phase + 1)) begin
        case ($urandom_range(9))
          0:       n = 9'd2;
          1:       n = 9'd0;
          2:       n = 9'd1;
          3:       n = (phase == 1) ? 9'd256 : 9'($urandom_range(2, 40));
          default: n = 9'($urandom_range(2, 16));
        endcase
        set_point_count(n);
        if (n >= 2 && n <= 256) load_sorted(n);
        // noise: random writes anywhere, which may unsort the table
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 4)) write_point($urandom_range(255), $urandom, $urandom);
        repeat ($urandom_range(4, 10)) begin
          aimed_query();
          // let the receiver catch up fully once in a while
          if ($urandom_range(40) == 0) drain();
        end
      end
    end

    drain();
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("piecewise_linear_table_interp_tb passed");
    end else begin
      $display("piecewise_linear_table_interp_tb failed");
    end
    $finish;
  end
endmodule

// ===== piecewise_linear_table_interp.f =====
rtl/plti_pkg.sv
rtl/plti_if.sv
rtl/plti_cell.sv
rtl/plti_muldiv.sv
rtl/piecewise_linear_table_interp.sv
test/piecewise_linear_table_interp_tb.sv
